### rtl/mesf_pkg.sv
// ----------------------------------------------------------------------------
// mesf_pkg
// Shared widths and constants for the median / smoothing sample filter.
// ----------------------------------------------------------------------------
package mesf_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int RAW_W    = 15;
  localparam int CNT_W    = 4;

  // set size default and saturation limit of the sample counter
  localparam int                SAMPLES_DEF = 5;
  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

  // raw_max value after reset
  localparam logic [RAW_W-1:0]  RAW_MAX_RESET = 15'd4095;

  // smoothing: (7*old + new + 4) / 8
  localparam int                EWMA_SHIFT = 3;
  localparam int                EWMA_W     = RAW_W + EWMA_SHIFT + 1;
  localparam logic [EWMA_W-1:0] EWMA_ROUND = EWMA_W'(4);

endpackage

### rtl/mesf_sorter.sv
// ----------------------------------------------------------------------------
// mesf_sorter
// Sorted sample store with parallel compare-and-shift insertion; gives the
// middle entry as it stands after the current insertion.
// ----------------------------------------------------------------------------
module mesf_sorter #(
  parameter int SAMPLES = mesf_pkg::SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 insert_en,
  input  logic        [mesf_pkg::CNT_W-1:0]    fill,
  input  logic signed [mesf_pkg::SAMPLE_W-1:0] sample_value,
  output logic signed [mesf_pkg::SAMPLE_W-1:0] median
);
  import mesf_pkg::*;

  localparam int MID = SAMPLES / 2;

  logic signed [SAMPLE_W-1:0] sorted      [SAMPLES];
  logic signed [SAMPLE_W-1:0] sorted_next [SAMPLES];
  logic        [SAMPLES-1:0]  gt;
  logic        [SAMPLES:0]    gt_below;

  // entries already filled that lie above the new sample
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      gt[i] = (CNT_W'(i) < fill) && (sorted[i] > sample_value);
    end
  end

  assign gt_below = {gt, 1'b0};

  // shift larger entries up one place, drop the new sample into the gap
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      if (CNT_W'(i) > fill) begin
        sorted_next[i] = sorted[i];
      end else if (gt_below[i]) begin
        sorted_next[i] = sorted[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || (CNT_W'(i) == fill)) begin
        sorted_next[i] = sample_value;
      end else begin
        sorted_next[i] = sorted[i];
      end
    end
  end

  assign median = sorted_next[MID];

  // store update
  always_ff @(posedge clk) begin
    if (insert_en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        sorted[i] <= sorted_next[i];
      end
    end
  end

endmodule

### rtl/median_ewma_sample_filter_unit.sv
// ----------------------------------------------------------------------------
// median_ewma_sample_filter_unit
// Median of each sample set followed by exponentially weighted smoothing.
// ----------------------------------------------------------------------------
// Samples go through an input register and are then inserted into the sorted
// store; the marked last sample of a set loads one result into the output
// register as it is inserted. One sample is taken per clock, limited by the
// compare-and-shift insert and the smoothing adder; unmarked samples still
// pass while a result waits; a marked last sample waits until it is taken.
// A set is accepted (ok=1) when it holds exactly SAMPLES samples, all in
// 0..raw_max; its median then seeds or updates the average as
// (7*old + median + 4)/8. A rejected set gives filtered=0, ok=0. The user
// must write raw_max through the cfg channel while idle; not enforced.
// ----------------------------------------------------------------------------
module median_ewma_sample_filter_unit #(
  parameter int SAMPLES = mesf_pkg::SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [mesf_pkg::RAW_W-1:0]    cfg_data,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mesf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_sample,
  input  logic                                 restart,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [mesf_pkg::RAW_W-1:0]    filtered,
  output logic                                 ok
);
  import mesf_pkg::*;

  localparam logic [CNT_W-1:0] SET_SIZE = CNT_W'(SAMPLES);

  logic [RAW_W-1:0] raw_max;

  // input register
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       s1_last;
  logic                       s1_restart;
  logic                       s1_fire;

  // filter state
  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] sample_count_next;
  logic             set_bad;
  logic             set_bad_next;
  logic             seeded;
  logic [RAW_W-1:0] smoothed;
  logic [RAW_W-1:0] smoothed_next;

  logic                       insert_en;
  logic                       out_range;
  logic                       seeded_eff;
  logic                       accepted;
  logic signed [SAMPLE_W-1:0] median;
  logic [EWMA_W-1:0]          ewma_sum;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_max <= RAW_MAX_RESET;
    end else if (cfg_valid) begin
      raw_max <= cfg_data;
    end
  end

  // pipeline control: a sample with no result never waits on the output
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample  <= sample;
      s1_last    <= last_sample;
      s1_restart <= restart;
    end
  end

  // sorted store
  assign insert_en = s1_fire && (sample_count < SET_SIZE);

  mesf_sorter #(
    .SAMPLES (SAMPLES)
  ) u_sorter (
    .clk          (clk),
    .insert_en    (insert_en),
    .fill         (sample_count),
    .sample_value (s1_sample),
    .median       (median)
  );

  // set bookkeeping
  assign out_range = s1_sample[SAMPLE_W-1] || (s1_sample[RAW_W-1:0] > raw_max);

  always_comb begin
    set_bad_next      = set_bad || out_range || (sample_count >= SET_SIZE);
    sample_count_next = (sample_count == CNT_MAX) ? CNT_MAX : sample_count + 1'b1;
  end

  assign accepted   = !set_bad_next && (sample_count_next == SET_SIZE);
  assign seeded_eff = seeded && !s1_restart;

  // smoothing: 7*old = 8*old - old
  assign ewma_sum = ({1'b0, smoothed, {EWMA_SHIFT{1'b0}}} - EWMA_W'(smoothed))
                    + EWMA_W'(median[RAW_W-1:0]) + EWMA_ROUND;

  always_comb begin
    if (seeded_eff) begin
      smoothed_next = ewma_sum[EWMA_SHIFT +: RAW_W];
    end else begin
      smoothed_next = median[RAW_W-1:0];
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      set_bad      <= 1'b0;
      seeded       <= 1'b0;
      smoothed     <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        sample_count <= '0;
        set_bad      <= 1'b0;
        if (accepted) begin
          smoothed <= smoothed_next;
          seeded   <= 1'b1;
        end else begin
          seeded   <= seeded_eff;
        end
      end else begin
        sample_count <= sample_count_next;
        set_bad      <= set_bad_next;
        seeded       <= seeded_eff;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      filtered <= accepted ? smoothed_next : '0;
      ok       <= accepted;
    end
  end

endmodule

### sim/median_filter_checker.sv
// ----------------------------------------------------------------------------
// median_filter_checker
// Watches the config, sample and result channels of the median / smoothing
// filter, keeps its own model of the sorted set and the running average,
// and compares every result transaction against the oldest expected one.
// ----------------------------------------------------------------------------
module median_filter_checker #(
  parameter int SAMPLES = mesf_pkg::SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [mesf_pkg::RAW_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [mesf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_sample,
  input  logic                                 restart,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic        [mesf_pkg::RAW_W-1:0]    filtered,
  input  logic                                 ok,
  output int                                   errors,
  output int                                   pending
);
  import mesf_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RAW_W-1:0] filtered;
    logic             ok;
  } filter_result_t;

  // predicted filter state
  logic signed [SAMPLE_W-1:0] sorted_set [SAMPLES];
  logic        [CNT_W-1:0]    set_count;
  logic                       set_bad;
  logic                       seeded;
  logic        [SAMPLE_W-1:0] smoothed;
  logic        [RAW_W-1:0]    raw_max;

  filter_result_t expected_results [$];
  filter_result_t want;
  int             reports;

  // one sample through the filter; a marked sample queues one result
  task automatic advance_filter(input logic signed [SAMPLE_W-1:0] v,
                                input logic lst, input logic rs);
    int             j;
    int             median;
    int             acc;
    logic           accepted;
    filter_result_t r;
    if (rs) seeded = 1'b0;
    if (int'(v) < 0 || int'(v) > int'(raw_max)) set_bad = 1'b1;
    // compare-and-shift insert, only while the set has room
    if (set_count < SAMPLES) begin
      j = set_count;
      while (j > 0 && sorted_set[j-1] > v) begin
        sorted_set[j] = sorted_set[j-1];
        j--;
      end
      sorted_set[j] = v;
    end else begin
      set_bad = 1'b1;
    end
    if (set_count != CNT_MAX) set_count++;
    if (lst) begin
      accepted  = !set_bad && set_count == SAMPLES;
      set_count = '0;
      set_bad   = 1'b0;
      r.filtered = '0;
      r.ok       = 1'b0;
      if (accepted) begin
        median = int'(sorted_set[SAMPLES/2]);
        if (!seeded) begin
          smoothed = SAMPLE_W'(median);
          seeded   = 1'b1;
        end else begin
          acc      = int'(smoothed) * 7 + median + 4;
          smoothed = SAMPLE_W'(acc / 8);
        end
        r.filtered = smoothed[RAW_W-1:0];
        r.ok       = 1'b1;
      end
      expected_results.push_back(r);
    end
  endtask

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (sorted_set[i]) sorted_set[i] = '0;
      set_count = '0;
      set_bad   = 1'b0;
      seeded    = 1'b0;
      smoothed  = '0;
      raw_max   = RAW_MAX_RESET;
      expected_results.delete();
      errors    = 0;
      reports   = 0;
    end else begin
      if (cfg_valid && cfg_ready) raw_max = cfg_data;
      if (in_valid && in_ready) advance_filter(sample, last_sample, restart);
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("[%0t] unexpected result: filtered=%0d ok=%0b", $realtime,
                     filtered, ok);
          end
        end else begin
          want = expected_results.pop_front();
          if (filtered !== want.filtered || ok !== want.ok) begin
            errors++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display({"[%0t] result mismatch: expected filtered=%0d ok=%0b,",
                        " got filtered=%0d ok=%0b"},
                       $realtime, want.filtered, want.ok, filtered, ok);
            end
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the median / smoothing sample filter: directed sets for the
// edge cases, then random sets under several raw_max settings with random
// idling on both channels, a long output hold and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import mesf_pkg::*;

  localparam int SAMPLES          = SAMPLES_DEF;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 100;
  localparam int PHASE_SAMPLES    = 80;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic        [RAW_W-1:0]    cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;
  logic                       restart;
  logic                       out_valid;
  logic                       out_ready;
  logic        [RAW_W-1:0]    filtered;
  logic                       ok;
  int                         errors;
  int                         pending;

  int   cycle_count  = 0;
  int   samples_sent = 0;
  logic gaps_on;
  logic stalls_on;
  logic long_hold;

  median_ewma_sample_filter_unit #(.SAMPLES(SAMPLES)) u_dut (.*);
  median_filter_checker #(.SAMPLES(SAMPLES)) u_checker (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result receiver: random stall bursts, or one long hold on request
  initial begin
    logic hold_served;
    hold_served = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_served) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one sample transaction, valid left high afterwards
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst,
                             input logic rs);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= lst;
    restart     <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // stop offering and wait until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // raw_max write, only with the block idle
  task automatic write_raw_max(input logic [RAW_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random set: mostly well formed and in range, some broken
  task automatic send_set(input logic [RAW_W-1:0] lim);
    int                         len;
    int                         rs_at;
    int                         pick;
    logic signed [SAMPLE_W-1:0] s;
    len   = ($urandom_range(0, 9) < 7) ? SAMPLES : $urandom_range(1, 18);
    rs_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 16)      s = SAMPLE_W'($urandom_range(0, lim));
      else if (pick < 18) s = SAMPLE_W'(int'(lim) + $urandom_range(0, 1));
      else                s = SAMPLE_W'($urandom);
      push_sample(s, k == len - 1, k == rs_at);
    end
  endtask

  initial begin
    logic [RAW_W-1:0] lim;
    int               target;
    logic             hold_done;
    logic             paused;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    sample      = '0;
    last_sample = 1'b0;
    restart     = 1'b0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    long_hold   = 1'b0;
    hold_done   = 1'b0;
    paused      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first accepted set seeds the average, extremes of the default range
    push_sample(16'sd4095, 1'b0, 1'b0);
    push_sample(16'sd0,    1'b0, 1'b0);
    push_sample(16'sd2000, 1'b0, 1'b0);
    push_sample(16'sd4095, 1'b0, 1'b0);
    push_sample(16'sd1,    1'b1, 1'b0);
    // restart on the marked sample reseeds from this set
    push_sample(16'sd500,  1'b0, 1'b0);
    push_sample(16'sd300,  1'b0, 1'b0);
    push_sample(16'sd100,  1'b0, 1'b0);
    push_sample(16'sd200,  1'b0, 1'b0);
    push_sample(16'sd400,  1'b1, 1'b1);
    // one sample above raw_max, descending order
    push_sample(16'sd4096, 1'b0, 1'b0);
    push_sample(16'sd3,    1'b0, 1'b0);
    push_sample(16'sd2,    1'b0, 1'b0);
    push_sample(16'sd1,    1'b0, 1'b0);
    push_sample(16'sd0,    1'b1, 1'b0);
    // short set with the most negative and most positive sample
    push_sample(16'sh8000, 1'b0, 1'b0);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    // set longer than SAMPLES
    for (int k = 1; k <= SAMPLES + 2; k++)
      push_sample(SAMPLE_W'(k), k == SAMPLES + 2, 1'b0);

    // random phases over several raw_max settings
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       lim = {RAW_W{1'b1}};
        1:       lim = '0;
        4:       lim = RAW_MAX_RESET;
        default: lim = RAW_W'($urandom_range(1, 32766));
      endcase
      // final phase runs without idling
      if (phase == 4) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      write_raw_max(lim);
      target = samples_sent + PHASE_SAMPLES;
      while (samples_sent < target) begin
        send_set(lim);
        if (phase == 2 && !hold_done && samples_sent > target - 60) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        if (phase == 3 && !paused && samples_sent > target - 40) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
